>>> src/ytpq_pkg.sv
// ----------------------------------------------------------------------------
// ytpq_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package ytpq_pkg;

    localparam int DEF_MAX_ROWS = 8;
    localparam int DEF_MAX_COLS = 8;

    localparam int KEY_W = 32;
    localparam int DIM_W = 4;

    // empty cell marker: largest signed 32-bit value
    localparam logic signed [KEY_W-1:0] SENTINEL = 32'sh7FFF_FFFF;

    localparam logic [DIM_W-1:0] ROWS_RESET = 4'd8;
    localparam logic [DIM_W-1:0] COLS_RESET = 4'd8;

    // register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // operation codes
    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_FIND    = 2'd2
    } t_op;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic clr;       // write sentinel at clear pointer
        logic start;     // latch operation and key, set start position
        logic rd_nb;     // read neighbours instead of current cell
        logic ev0;       // evaluate current cell
        logic evn;       // evaluate neighbours, swap when needed
        logic fin;       // write held value at current position
        logic out_load;  // copy result into output register
    } t_dp_cmd;

    typedef struct packed {
        logic       clr_last;
        logic       no_nb;
        logic       stop;
        logic       v_sent;
        logic       find_exit;
        logic [1:0] op;
    } t_dp_sts;

endpackage

>>> src/ytpq_ctrl.sv
// ----------------------------------------------------------------------------
// ytpq_ctrl
// sequencer for clearing, insert, extract and find walks
// ----------------------------------------------------------------------------
module ytpq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_operation,
    input  logic              i_out_stall,
    input  ytpq_pkg::t_dp_sts i_sts,
    output ytpq_pkg::t_dp_cmd o_cmd,
    output logic              o_in_stall,
    output logic              o_out_valid
);
    import ytpq_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_RD0   = 8'b0000_0100,
        S_EV0   = 8'b0000_1000,
        S_NB    = 8'b0001_0000,
        S_EVN   = 8'b0010_0000,
        S_FIN   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    assign accept = (r_state == S_IDLE) && i_in_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.start = 1'b1;
                    if (i_operation == OP_INSERT || i_operation == OP_EXTRACT ||
                        i_operation == OP_FIND) begin
                        n_state = S_RD0;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RD0: n_state = S_EV0;
            S_EV0: begin
                o_cmd.ev0 = 1'b1;
                case (i_sts.op)
                    OP_INSERT:  n_state = i_sts.v_sent ? S_NB : S_DONE;
                    OP_EXTRACT: n_state = i_sts.v_sent ? S_DONE : S_NB;
                    default:    n_state = i_sts.find_exit ? S_DONE : S_RD0;
                endcase
            end
            S_NB: begin
                o_cmd.rd_nb = 1'b1;
                n_state = i_sts.no_nb ? S_FIN : S_EVN;
            end
            S_EVN: begin
                o_cmd.evn = 1'b1;
                n_state = i_sts.stop ? S_FIN : S_NB;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> src/ytpq_dp.sv
// ----------------------------------------------------------------------------
// ytpq_dp
// cell memory, walk position, neighbour compare and result registers
// ----------------------------------------------------------------------------
module ytpq_dp #(
    parameter int MAX_ROWS = ytpq_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = ytpq_pkg::DEF_MAX_COLS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ytpq_pkg::t_dp_cmd                i_cmd,
    output ytpq_pkg::t_dp_sts                o_sts,
    input  logic [ytpq_pkg::DIM_W-1:0]       i_rows,
    input  logic [ytpq_pkg::DIM_W-1:0]       i_cols,
    input  logic [1:0]                       i_operation,
    input  logic signed [ytpq_pkg::KEY_W-1:0] i_key,
    output logic signed [ytpq_pkg::KEY_W-1:0] o_min_key,
    output logic                             o_found,
    output logic [1:0]                       o_status
);
    import ytpq_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic [KEY_W-1:0] mem [DEPTH];

    logic [AW-1:0]           r_clr_addr;
    logic [RW-1:0]           r_r;
    logic [CW-1:0]           r_c;
    logic [1:0]              r_op;
    logic signed [KEY_W-1:0] r_val;
    logic signed [KEY_W-1:0] r_rd_a, r_rd_b;
    logic signed [KEY_W-1:0] r_res_min;
    logic                    r_res_found;
    logic [1:0]              r_res_status;
    logic signed [KEY_W-1:0] r_out_min;
    logic                    r_out_found;
    logic [1:0]              r_out_status;

    logic [RW-1:0]    nr_m1;
    logic [CW-1:0]    nc_m1;
    logic [6:0]       rows_ext, cols_ext;
    logic             has_up, has_left, has_down, has_right, both;
    logic             go_a, stop;
    logic signed [KEY_W-1:0] nb;
    logic [AW-1:0]    ra_a, ra_b, wa;
    logic [KEY_W-1:0] wd;
    logic             we;
    logic             is_ins;
    logic             hit, a_gt;

    function automatic logic [AW-1:0] f_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
        return AW'(32'(r) * MAX_COLS + 32'(c));
    endfunction

    // clamp dims: zero acts as one, above the parameter acts as the parameter
    always_comb begin
        rows_ext = {3'b000, i_rows};
        cols_ext = {3'b000, i_cols};
        if (rows_ext == 7'd0)                nr_m1 = '0;
        else if (rows_ext > 7'(MAX_ROWS))    nr_m1 = RW'(MAX_ROWS - 1);
        else                                 nr_m1 = RW'(rows_ext - 7'd1);
        if (cols_ext == 7'd0)                nc_m1 = '0;
        else if (cols_ext > 7'(MAX_COLS))    nc_m1 = CW'(MAX_COLS - 1);
        else                                 nc_m1 = CW'(cols_ext - 7'd1);
    end

    assign is_ins    = (r_op == OP_INSERT);
    assign has_up    = (r_r != '0);
    assign has_left  = (r_c != '0);
    assign has_down  = (r_r < nr_m1);
    assign has_right = (r_c < nc_m1);

    // port a: up or down, port b: left or right
    always_comb begin
        if (!i_cmd.rd_nb) begin
            ra_a = f_addr(r_r, r_c);
            ra_b = f_addr(r_r, r_c);
        end else if (is_ins) begin
            ra_a = f_addr(has_up ? r_r - RW'(1) : r_r, r_c);
            ra_b = f_addr(r_r, has_left ? r_c - CW'(1) : r_c);
        end else begin
            ra_a = f_addr(has_down ? r_r + RW'(1) : r_r, r_c);
            ra_b = f_addr(r_r, has_right ? r_c + CW'(1) : r_c);
        end
    end

    // neighbour choice; ties go left on insert, down on extract
    always_comb begin
        if (is_ins) begin
            both = has_up && has_left;
            go_a = both ? (r_rd_a > r_rd_b) : has_up;
            nb   = go_a ? r_rd_a : r_rd_b;
            stop = (nb <= r_val);
        end else begin
            both = has_down && has_right;
            go_a = both ? (r_rd_a <= r_rd_b) : has_down;
            nb   = go_a ? r_rd_a : r_rd_b;
            stop = (nb >= r_val);
        end
    end

    assign hit  = (r_rd_a == r_val);
    assign a_gt = (r_rd_a > r_val);

    always_comb begin
        we = 1'b0;
        wa = f_addr(r_r, r_c);
        wd = r_val;
        if (i_cmd.clr) begin
            we = 1'b1;
            wa = r_clr_addr;
            wd = SENTINEL;
        end else if (i_cmd.evn && !stop) begin
            we = 1'b1;
            wd = nb;
        end else if (i_cmd.fin) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        r_rd_a <= mem[ra_a];
        r_rd_b <= mem[ra_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op         <= i_operation;
            r_val        <= i_key;
            r_res_min    <= '0;
            r_res_found  <= 1'b0;
            r_res_status <= ST_DONE;
            case (i_operation)
                OP_INSERT: begin
                    r_r <= nr_m1;
                    r_c <= nc_m1;
                end
                OP_FIND: begin
                    r_r <= '0;
                    r_c <= nc_m1;
                end
                default: begin
                    r_r <= '0;
                    r_c <= '0;
                end
            endcase
        end
        if (i_cmd.ev0) begin
            case (r_op)
                OP_INSERT: begin
                    if (r_rd_a != SENTINEL) r_res_status <= ST_FULL;
                end
                OP_EXTRACT: begin
                    r_res_min <= r_rd_a;
                    if (r_rd_a == SENTINEL) r_res_status <= ST_EMPTY;
                    else r_val <= SENTINEL;
                end
                default: begin
                    if (hit) r_res_found <= 1'b1;
                    else if (a_gt) r_c <= r_c - CW'(1);
                    else r_r <= r_r + RW'(1);
                end
            endcase
        end
        if (i_cmd.evn && !stop) begin
            if (is_ins) begin
                if (go_a) r_r <= r_r - RW'(1);
                else r_c <= r_c - CW'(1);
            end else begin
                if (go_a) r_r <= r_r + RW'(1);
                else r_c <= r_c + CW'(1);
            end
        end
        if (i_cmd.out_load) begin
            r_out_min    <= r_res_min;
            r_out_found  <= r_res_found;
            r_out_status <= r_res_status;
        end
    end

    assign o_sts.clr_last  = (r_clr_addr == AW'(DEPTH - 1));
    assign o_sts.no_nb     = is_ins ? (!has_up && !has_left) : (!has_down && !has_right);
    assign o_sts.stop      = stop;
    assign o_sts.v_sent    = (r_rd_a == SENTINEL);
    assign o_sts.find_exit = hit || (a_gt ? (r_c == '0) : (r_r == nr_m1));
    assign o_sts.op        = r_op;

    assign o_min_key = r_out_min;
    assign o_found   = r_out_found;
    assign o_status  = r_out_status;

endmodule

>>> src/young_tableau_priority_queue_top.sv
// throughput: one word at a time; the next word is accepted the cycle after
//   the result is loaded, so a stalled result holds off the input
// reset: synchronous active low; a clearing pass then writes the sentinel to
//   all MAX_ROWS*MAX_COLS cells, one per cycle, with input stalled meanwhile
// ----------------------------------------------------------------------------
// young_tableau_priority_queue_top
// young tableau priority queue with insert, extract-min and staircase find
// ----------------------------------------------------------------------------
module young_tableau_priority_queue_top #(
    parameter int MAX_ROWS = ytpq_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = ytpq_pkg::DEF_MAX_COLS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [ytpq_pkg::DIM_W-1:0]        i_cfg_data,
    // input word
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_operation,
    input  logic signed [ytpq_pkg::KEY_W-1:0] i_key,
    // result word
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [ytpq_pkg::KEY_W-1:0] o_min_key,
    output logic                              o_found,
    output logic [1:0]                        o_status
);
    import ytpq_pkg::*;

    // active corner size registers, kept as written
    logic [DIM_W-1:0] r_rows_in_use;
    logic [DIM_W-1:0] r_cols_in_use;

    t_dp_cmd cmd;
    t_dp_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= ROWS_RESET;
            r_cols_in_use <= COLS_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_ROWS) r_rows_in_use <= i_cfg_data;
            if (i_cfg_index == CFG_COLS) r_cols_in_use <= i_cfg_data;
        end
    end

    // sequencer: clear pass, then one operation walk at a time
    ytpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // cell memory, walk position and result word register
    ytpq_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_rows      (r_rows_in_use),
        .i_cols      (r_cols_in_use),
        .i_operation (i_operation),
        .i_key       (i_key),
        .o_min_key   (o_min_key),
        .o_found     (o_found),
        .o_status    (o_status)
    );

    // input is held off during the clearing pass after reset
    a_stall_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    // a find hit never comes with a failure status
    a_found_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_status == ST_DONE))
        else $error("found with non-done status");

    // a rejected insert reports no key
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> (o_min_key == '0 && !o_found))
        else $error("full status with payload");

    // an empty extract reports the sentinel
    a_empty_sent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_EMPTY) |-> (o_min_key == SENTINEL))
        else $error("empty status without sentinel");

endmodule

>>> sim/young_tableau_priority_queue_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// young_tableau_priority_queue_top_tb
// checks insert, extract-min and find of the tableau queue against an
// in-bench tableau model, under random bursts, gaps, stalls and resizes
// ----------------------------------------------------------------------------
module young_tableau_priority_queue_top_tb;
    import ytpq_pkg::*;

    localparam int NR_MAX = 8;
    localparam int NC_MAX = 8;
    localparam int CYCLE_LIMIT = 1500000;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic                     cfg_index = CFG_ROWS;
    logic [DIM_W-1:0]         cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [1:0]               operation = '0;
    logic signed [KEY_W-1:0]  key = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [KEY_W-1:0]  min_key;
    logic                     found;
    logic [1:0]               status;

    young_tableau_priority_queue_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_operation (operation),
        .i_key       (key),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_min_key   (min_key),
        .o_found     (found),
        .o_status    (status)
    );

    // expected result word
    typedef struct {
        logic signed [KEY_W-1:0] min_key;
        logic                    found;
        logic [1:0]              status;
    } t_answer;

    // tableau model state
    logic signed [KEY_W-1:0] grid [NR_MAX][NC_MAX];
    logic [DIM_W-1:0]        rows_reg;
    logic [DIM_W-1:0]        cols_reg;
    t_answer                 answers [$];
    int                      errors = 0;
    int                      cycles = 0;
    int                      hold_off = 0;   // long receiver hold-off, in cycles
    bit                      stall_rand = 1'b1;
    logic signed [KEY_W-1:0] recent [$];     // keys likely present, for finds

    initial forever #2 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("young_tableau_priority_queue_top_tb failed");
            $finish;
        end
    end

    function automatic int eff_dim(logic [DIM_W-1:0] v, int lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return int'(v);
    endfunction

    // bubble-up insert, left neighbor wins ties
    function automatic logic [1:0] tableau_insert(logic signed [KEY_W-1:0] k, int nr, int nc);
        int r, c;
        bit up;
        logic signed [KEY_W-1:0] t;
        r = nr - 1;
        c = nc - 1;
        if (grid[r][c] != SENTINEL) return ST_FULL;
        grid[r][c] = k;
        while (r > 0 || c > 0) begin
            if (r > 0 && c > 0) up = grid[r-1][c] > grid[r][c-1];
            else up = (r > 0);
            if (up) begin
                if (grid[r-1][c] <= grid[r][c]) break;
                t = grid[r-1][c]; grid[r-1][c] = grid[r][c]; grid[r][c] = t;
                r--;
            end else begin
                if (grid[r][c-1] <= grid[r][c]) break;
                t = grid[r][c-1]; grid[r][c-1] = grid[r][c]; grid[r][c] = t;
                c--;
            end
        end
        return ST_DONE;
    endfunction

    // sink the sentinel, lower neighbor wins ties
    function automatic logic [1:0] tableau_extract(output logic signed [KEY_W-1:0] m,
                                                   input int nr, input int nc);
        int r, c;
        bit down, hd, hr;
        logic signed [KEY_W-1:0] t;
        r = 0;
        c = 0;
        m = grid[0][0];
        if (m == SENTINEL) return ST_EMPTY;
        grid[0][0] = SENTINEL;
        forever begin
            hd = (r + 1 < nr);
            hr = (c + 1 < nc);
            if (!hd && !hr) break;
            if (hd && hr) down = grid[r+1][c] <= grid[r][c+1];
            else down = hd;
            if (down) begin
                if (grid[r+1][c] >= grid[r][c]) break;
                t = grid[r+1][c]; grid[r+1][c] = grid[r][c]; grid[r][c] = t;
                r++;
            end else begin
                if (grid[r][c+1] >= grid[r][c]) break;
                t = grid[r][c+1]; grid[r][c+1] = grid[r][c]; grid[r][c] = t;
                c++;
            end
        end
        return ST_DONE;
    endfunction

    function automatic bit tableau_find(logic signed [KEY_W-1:0] k, int nr, int nc);
        int r, c;
        r = 0;
        c = nc;
        while (r < nr && c > 0) begin
            if (grid[r][c-1] == k) return 1'b1;
            if (grid[r][c-1] > k) c--;
            else r++;
        end
        return 1'b0;
    endfunction

    function automatic t_answer predict_answer(logic [1:0] op, logic signed [KEY_W-1:0] k);
        t_answer a;
        int nr, nc;
        nr = eff_dim(rows_reg, NR_MAX);
        nc = eff_dim(cols_reg, NC_MAX);
        a.min_key = '0;
        a.found = 1'b0;
        a.status = ST_DONE;
        case (op)
            OP_INSERT:  a.status = tableau_insert(k, nr, nc);
            OP_EXTRACT: a.status = tableau_extract(a.min_key, nr, nc);
            OP_FIND:    a.found = tableau_find(k, nr, nc);
            default: ;
        endcase
        return a;
    endfunction

    // send one word, predicting at acceptance
    task automatic send_word(logic [1:0] op, logic signed [KEY_W-1:0] k);
        in_valid <= 1'b1;
        operation <= op;
        key <= k;
        do @(posedge clk); while (in_stall);
        answers.insert(answers.size(), predict_answer(op, k));
        if (op == OP_INSERT && recent.size() < 64) recent.insert(recent.size(), k);
    endtask

    task automatic idle_sender(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // wait for all answers plus the longest walk
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (answers.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [DIM_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_ROWS) rows_reg = v;
        else cols_reg = v;
        @(posedge clk);
    endtask

    task automatic set_shape(logic [DIM_W-1:0] r, logic [DIM_W-1:0] c);
        drain();
        write_reg(CFG_ROWS, r);
        write_reg(CFG_COLS, c);
    endtask

    function automatic logic signed [KEY_W-1:0] random_key();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFE;
            2: return $urandom;
            default: return $signed($urandom_range(0, 40)) - 20;
        endcase
    endfunction

    // receiver stall pattern, with an optional long hold-off
    always @(posedge clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_stall <= 1'b1;
        end else if (stall_rand)
            out_stall <= ($urandom_range(0, 3) == 0);
        else
            out_stall <= 1'b0;
    end

    // result checker
    always @(posedge clk) begin
        t_answer a;
        if (rst_n && out_valid && !out_stall) begin
            if (answers.size() == 0) begin
                $error("result word with no expectation");
                errors++;
            end else begin
                a = answers.pop_front();
                if (min_key !== a.min_key) begin
                    $error("min_key expected %0d actual %0d", a.min_key, min_key);
                    errors++;
                end
                if (found !== a.found) begin
                    $error("found expected %0d actual %0d", a.found, found);
                    errors++;
                end
                if (status !== a.status) begin
                    $error("status expected %0d actual %0d", a.status, status);
                    errors++;
                end
            end
        end
    end

    // extremes, empty/full, sentinel insert and find, ties, code 3
    task automatic test_directed();
        send_word(OP_EXTRACT, 32'sd5);
        send_word(OP_FIND, SENTINEL);
        send_word(OP_INSERT, SENTINEL);
        send_word(OP_INSERT, 32'sh8000_0000);
        send_word(OP_INSERT, 32'sh7FFF_FFFE);
        send_word(OP_INSERT, 32'sd3);
        send_word(OP_INSERT, 32'sd3);
        send_word(OP_INSERT, -32'sd1);
        send_word(OP_FIND, 32'sd3);
        send_word(OP_FIND, 32'sd4);
        send_word(OP_FIND, 32'sh8000_0000);
        send_word(2'd3, 32'hFFFF_FFFF);
        repeat (4) send_word(OP_EXTRACT, '0);
        send_word(OP_EXTRACT, 32'hFFFF_FFFF);
        send_word(OP_EXTRACT, '0);
        send_word(OP_FIND, 32'sh7FFF_FFFE);
        // fill a 1x2 corner to force a full reject
        set_shape(4'd1, 4'd2);
        send_word(OP_INSERT, 32'sd7);
        send_word(OP_INSERT, 32'sd7);
        send_word(OP_INSERT, 32'sd9);
        send_word(OP_FIND, 32'sd7);
        send_word(OP_EXTRACT, '0);
        send_word(OP_EXTRACT, '0);
    endtask

    // random traffic on one shape, in bursts with gaps
    task automatic test_random_shape(logic [DIM_W-1:0] r, logic [DIM_W-1:0] c, int n);
        int sent;
        int burst;
        int pick;
        set_shape(r, c);
        sent = 0;
        while (sent < n) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                pick = $urandom_range(0, 9);
                if (pick < 4) send_word(OP_INSERT, random_key());
                else if (pick < 7) send_word(OP_EXTRACT, $urandom);
                else if (pick < 9 && recent.size() > 0)
                    send_word(OP_FIND, recent[$urandom_range(0, recent.size() - 1)]);
                else if (pick == 9 && $urandom_range(0, 3) == 0)
                    send_word(2'd3, $urandom);
                else send_word(OP_FIND, random_key());
                sent++;
            end
            if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 40));
        end
    endtask

    // resize with keys still held
    task automatic test_resize_live();
        set_shape(4'd8, 4'd8);
        repeat (30) send_word(OP_INSERT, random_key());
        set_shape(4'd3, 4'd5);
        repeat (20) send_word(2'($urandom_range(0, 2)), random_key());
        set_shape(4'd0, 4'd15);
        repeat (20) send_word(2'($urandom_range(0, 2)), random_key());
        set_shape(4'd15, 4'd0);
        repeat (20) send_word(2'($urandom_range(0, 2)), random_key());
        set_shape(4'd8, 4'd8);
        repeat (70) send_word(OP_EXTRACT, '0);
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        set_shape(4'd4, 4'd4);
        hold_off = 300;
        repeat (30) send_word(2'($urandom_range(0, 1)), random_key());
        drain();
        stall_rand = 1'b0;
        repeat (40) send_word(2'($urandom_range(0, 2)), random_key());
        stall_rand = 1'b1;
    endtask

    initial begin
        int k;
        rows_reg = ROWS_RESET;
        cols_reg = COLS_RESET;
        for (int r = 0; r < NR_MAX; r++)
            for (int c = 0; c < NC_MAX; c++) grid[r][c] = SENTINEL;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_resize_live();
        test_backpressure();
        for (k = 0; k < 12; k++)
            test_random_shape(4'($urandom_range(1, 8)), 4'($urandom_range(1, 8)), 90);
        test_random_shape(4'd8, 4'd8, 150);
        test_random_shape(4'd1, 4'd1, 60);
        drain();
        if (errors == 0)
            $display("young_tableau_priority_queue_top_tb passed");
        else
            $display("young_tableau_priority_queue_top_tb failed");
        $finish;
    end

endmodule

>>> young_tableau_priority_queue_top.f
src/ytpq_pkg.sv
src/ytpq_ctrl.sv
src/ytpq_dp.sv
src/young_tableau_priority_queue_top.sv
sim/young_tableau_priority_queue_top_tb.sv
